>>> hdl/assert_macros.svh
// assertion macros used by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/bpe_pkg.sv
// constants, types and helper functions of the barcode pattern extractor
package bpe_pkg;

  // pattern and position sizing
  localparam int MAX_PATTERN   = 32;
  localparam int POSITION_BITS = 16;
  localparam int IDX_W         = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W         = $clog2(MAX_PATTERN + 1);
  localparam int POS_W         = POSITION_BITS + 1;

  // fixed field widths
  localparam int SYM_W     = 8;
  localparam int START_W   = 16;
  localparam int MLEN_W    = 6;
  localparam int PLEN_W    = 6;
  localparam int BASES_W   = 64;
  localparam int MASK_W    = 32;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 64;

  // saturation limits of the read position and of the match start
  localparam longint unsigned POS_MAX   = (64'd1 << POSITION_BITS) - 64'd1;
  localparam longint unsigned SEEN_MAX  = POS_MAX + longint'(MAX_PATTERN);
  localparam longint unsigned START_MAX = (POS_MAX < 64'd65535) ? POS_MAX : 64'd65535;

  // character codes
  localparam logic [SYM_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [SYM_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [SYM_W-1:0] CASE_OFFSET  = 8'h20;

  typedef logic [SYM_W-1:0] sym_t;
  typedef sym_t [MAX_PATTERN-1:0] win_t;

  // upper-case base letters, indexed by 2-bit base code
  localparam sym_t BASE_CHARS [4] = '{8'h41, 8'h43, 8'h47, 8'h54};

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BASES  = 4'd0,
    CFG_WILDCARD_MASK  = 4'd1,
    CFG_CAPTURE_MASK   = 4'd2,
    CFG_PATTERN_LENGTH = 4'd3
  } cfg_reg_t;

  // case-insensitive compare of a read character against a base code
  function automatic logic base_match(sym_t c, logic [1:0] code);
    sym_t up;
    up = c;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) up = c - CASE_OFFSET;
    return up == BASE_CHARS[code];
  endfunction

endpackage

>>> hdl/barcode_pattern_extractor.sv
// top level of the barcode pattern extractor
//
// Read characters arrive on the in_ channel (in_symbol, in_last_of_read), one
// transaction per character, valid/ready. Results leave on the out_ channel,
// one transaction per result. The cfg_ channel writes the pattern registers
// (index 0 bases, 1 wildcard mask, 2 capture mask, 3 pattern length); it is
// always ready and should only be used while no read is in flight.
// An input transaction is registered and matched combinationally against the
// whole window; a match or end-of-read result goes to the result slot and then
// to the output register, which drives out_valid.
// Throughput is one character per cycle while the result slot is free. A match
// with k captured positions holds the result slot for k results (one if none is
// captured), one result per cycle while the receiver is ready; input stalls meanwhile.
// When the receiver stalls, the output register holds its result, the result
// slot and input register fill, and in_ready drops.
// Reset (synchronous, rst_n low) clears the window, read position, match flag
// and all valid flags, and restores the register defaults (length 1).
`include "assert_macros.svh"

module barcode_pattern_extractor (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bpe_pkg::SYM_W-1:0]       in_symbol,
  input  logic                            in_last_of_read,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_found,
  output logic [bpe_pkg::START_W-1:0]     out_match_start,
  output logic [bpe_pkg::MLEN_W-1:0]      out_match_length,
  output logic [bpe_pkg::SYM_W-1:0]       out_barcode_symbol,
  output logic                            out_symbol_valid,
  output logic                            out_last_of_run,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpe_pkg::CFG_DAT_W-1:0]   cfg_data
);

  localparam int MP = bpe_pkg::MAX_PATTERN;

  // configuration registers
  logic [bpe_pkg::BASES_W-1:0] bases_r;
  logic [bpe_pkg::MASK_W-1:0]  wild_r;
  logic [bpe_pkg::MASK_W-1:0]  cap_r;
  logic [bpe_pkg::PLEN_W-1:0]  plen_r;

  // read state
  bpe_pkg::win_t               window_r, window_nxt;
  logic [bpe_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic                        done_r, done_nxt;

  // input register
  logic                        a_valid_r;
  bpe_pkg::sym_t               a_sym_r;
  logic                        a_last_r;
  logic                        a_adv;

  // result slot
  logic                        job_valid_r;
  logic                        job_found_r;
  logic [bpe_pkg::START_W-1:0] job_start_r;
  logic [bpe_pkg::LEN_W-1:0]   job_len_r;
  bpe_pkg::win_t               job_syms_r;
  logic [MP-1:0]               job_mask_r;
  logic                        job_free;
  logic                        job_make;

  // output register
  logic                        out_valid_r;
  logic                        out_found_r;
  logic [bpe_pkg::START_W-1:0] out_start_r;
  logic [bpe_pkg::MLEN_W-1:0]  out_len_r;
  bpe_pkg::sym_t               out_sym_r;
  logic                        out_symv_r;
  logic                        out_last_r;
  logic                        out_load;

  // matching datapath
  logic [bpe_pkg::LEN_W-1:0]   len_used;
  bpe_pkg::win_t               win_sh;
  bpe_pkg::win_t               aligned;
  logic [MP-1:0]               len_mask;
  logic [MP-1:0]               pos_ok_vec;
  logic [bpe_pkg::POS_W-1:0]   pos_inc;
  logic [bpe_pkg::POS_W-1:0]   start_diff;
  logic [bpe_pkg::START_W-1:0] start_sat;
  logic                        hit;

  // run emitter
  logic [MP-1:0]               low_bit;
  logic [MP-1:0]               mask_rest;
  bpe_pkg::sym_t               sel_sym;

  // configuration writes, always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bases_r <= '0;
      wild_r  <= '0;
      cap_r   <= '0;
      plen_r  <= bpe_pkg::PLEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (bpe_pkg::cfg_reg_t'(cfg_index))
        bpe_pkg::CFG_PATTERN_BASES:  bases_r <= cfg_data;
        bpe_pkg::CFG_WILDCARD_MASK:  wild_r  <= cfg_data[bpe_pkg::MASK_W-1:0];
        bpe_pkg::CFG_CAPTURE_MASK:   cap_r   <= cfg_data[bpe_pkg::MASK_W-1:0];
        bpe_pkg::CFG_PATTERN_LENGTH: plen_r  <= cfg_data[bpe_pkg::PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register, refilled as soon as its transaction moves on
  assign job_free = !job_valid_r || (out_load && (mask_rest == '0));
  assign a_adv    = a_valid_r && job_free;
  assign in_ready = !a_valid_r || a_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_sym_r  <= in_symbol;
      a_last_r <= in_last_of_read;
    end
  end

  // clamp pattern length into 1..MAX_PATTERN
  always_comb begin
    if (plen_r == '0) begin
      len_used = bpe_pkg::LEN_W'(1);
    end else if (plen_r > bpe_pkg::PLEN_W'(MP)) begin
      len_used = bpe_pkg::LEN_W'(MP);
    end else begin
      len_used = bpe_pkg::LEN_W'(plen_r);
    end
  end

  // shifted window and its pattern-order view
  always_comb begin
    logic [bpe_pkg::LEN_W-1:0] idx;
    win_sh[0] = a_sym_r;
    for (int k = 1; k < MP; k++) begin
      win_sh[k] = window_r[k-1];
    end
    for (int i = 0; i < MP; i++) begin
      idx         = len_used - bpe_pkg::LEN_W'(1) - bpe_pkg::LEN_W'(i);
      len_mask[i] = bpe_pkg::LEN_W'(i) < len_used;
      aligned[i]  = win_sh[idx[bpe_pkg::IDX_W-1:0]];
    end
  end

  // per-position compare and window hit
  always_comb begin
    for (int i = 0; i < MP; i++) begin
      pos_ok_vec[i] = !len_mask[i] || wild_r[i] ||
                      bpe_pkg::base_match(aligned[i], bases_r[2*i +: 2]);
    end
  end

  assign pos_inc = (pos_r < bpe_pkg::POS_W'(bpe_pkg::SEEN_MAX)) ?
                   pos_r + bpe_pkg::POS_W'(1) : pos_r;
  assign hit     = (pos_inc >= bpe_pkg::POS_W'(len_used)) && (&pos_ok_vec);

  // saturated match start
  assign start_diff = pos_inc - bpe_pkg::POS_W'(len_used);
  assign start_sat  = (start_diff > bpe_pkg::POS_W'(bpe_pkg::START_MAX)) ?
                      bpe_pkg::START_W'(bpe_pkg::START_MAX) :
                      bpe_pkg::START_W'(start_diff);

  // read state update
  always_comb begin
    window_nxt = window_r;
    pos_nxt    = pos_r;
    done_nxt   = done_r;
    if (a_adv) begin
      if (!done_r) begin
        window_nxt = win_sh;
        pos_nxt    = pos_inc;
        if (hit) done_nxt = 1'b1;
      end
      if (a_last_r) begin
        window_nxt = '0;
        pos_nxt    = '0;
        done_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      pos_r    <= '0;
      done_r   <= 1'b0;
    end else begin
      window_r <= window_nxt;
      pos_r    <= pos_nxt;
      done_r   <= done_nxt;
    end
  end

  // a match or an unmatched end of read opens a run
  assign job_make = a_adv && !done_r && (hit || a_last_r);

  // next captured position of the run
  assign low_bit   = job_mask_r & (~job_mask_r + MP'(1));
  assign mask_rest = job_mask_r & ~low_bit;

  always_comb begin
    sel_sym = '0;
    for (int i = 0; i < MP; i++) begin
      if (low_bit[i]) sel_sym = sel_sym | job_syms_r[i];
    end
  end

  // result slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else if (job_make) begin
      job_valid_r <= 1'b1;
    end else if (out_load && (mask_rest == '0)) begin
      job_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_make) begin
      job_found_r <= hit;
      job_start_r <= hit ? start_sat : '0;
      job_len_r   <= hit ? len_used : '0;
      job_syms_r  <= aligned;
      job_mask_r  <= hit ? (wild_r[MP-1:0] & cap_r[MP-1:0] & len_mask) : '0;
    end else if (out_load) begin
      job_mask_r  <= mask_rest;
    end
  end

  // output register
  assign out_load = job_valid_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r <= job_found_r;
      out_start_r <= job_start_r;
      out_len_r   <= bpe_pkg::MLEN_W'(job_len_r);
      out_sym_r   <= sel_sym;
      out_symv_r  <= job_mask_r != '0;
      out_last_r  <= mask_rest == '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_match_start    = out_start_r;
  assign out_match_length   = out_len_r;
  assign out_barcode_symbol = out_sym_r;
  assign out_symbol_valid   = out_symv_r;
  assign out_last_of_run    = out_last_r;

  // checks
  `ASSERT_IMPL(a_no_run_after_match, done_r, !job_make, "run opened after a match")
  `ASSERT_NEXT(a_read_end_clears, a_adv && a_last_r, (pos_r == '0) && !done_r,
               "read state not cleared at end of read")
  `ASSERT_IMPL(a_not_found_shape, out_valid_r && !out_found_r,
               out_last_r && !out_symv_r && (out_len_r == '0),
               "malformed not-found result")
  `ASSERT_IMPL(a_make_needs_slot, job_make, job_free, "result slot overwritten")

endmodule
